@@ rtl/fdrc_pkg.sv @@
// Package for the fractional divider ratio configuration block.
// Holds field widths, word layout constants, the sequencer state type and
// the result type of the shared subtract unit. No dependencies.
package fdrc_pkg;

  // Transaction field widths
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned WORD_W = 19;

  // Divider word layout
  localparam int unsigned ENABLE_POS  = 0;
  localparam int unsigned STRETCH_POS = 2;
  localparam int unsigned FIELD_LSB   = 3;

  // Iteration counter for the restoring divider
  localparam int unsigned CNT_W = $clog2(FREQ_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FREQ_W - 1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_GCD_DONE,
    ST_DIV_IN,
    ST_DIV_OUT,
    ST_DIFF,
    ST_STRETCH,
    ST_SCALE,
    ST_PACK
  } state_e;

  // Result of the shared subtract unit
  typedef struct packed {
    logic              ge;
    logic [FREQ_W:0]   diff;
    logic [FREQ_W-1:0] absdiff;
  } sub_res_t;

endpackage

@@ rtl/fdrc_if.sv @@
// Valid/ready channel interfaces for the ratio request and the divider word.
// Depends on fdrc_pkg for field widths.
interface fdrc_req_if;
  import fdrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_in;
  logic [FREQ_W-1:0] freq_out;

  modport source (output valid, output freq_in, output freq_out, input ready);
  modport sink   (input valid, input freq_in, input freq_out, output ready);
endinterface

interface fdrc_rsp_if;
  import fdrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] divider_word;
  logic              ratio_error;

  modport source (output valid, output divider_word, output ratio_error, input ready);
  modport sink   (input valid, input divider_word, input ratio_error, output ready);
endinterface

@@ rtl/fdrc_sub_unit.sv @@
// Shared 33-bit subtract and compare unit used by the reduce, divide, difference and stretch steps.
// Depends on fdrc_pkg for the result struct.
module fdrc_sub_unit (
  input  logic [fdrc_pkg::FREQ_W:0] x_i,
  input  logic [fdrc_pkg::FREQ_W:0] y_i,
  output fdrc_pkg::sub_res_t        res_o
);
  import fdrc_pkg::*;

  logic [FREQ_W+1:0] wide_diff;
  logic [FREQ_W:0]   neg_diff;

  // x - y with borrow out; ge when no borrow
  assign wide_diff = {1'b0, x_i} - {1'b0, y_i};
  assign neg_diff  = ~wide_diff[FREQ_W:0] + (FREQ_W+1)'(1);

  assign res_o.ge      = ~wide_diff[FREQ_W+1];
  assign res_o.diff    = wide_diff[FREQ_W:0];
  assign res_o.absdiff = res_o.ge ? wide_diff[FREQ_W-1:0] : neg_diff[FREQ_W-1:0];

endmodule

@@ rtl/fractional_divider_ratio_config_unit.sv @@
// Channel  | Dir | Payload                         | Accepted when
// ---------+-----+---------------------------------+----------------------
// req_i    | in  | freq_in[31:0], freq_out[31:0]   | valid && ready
// rsp_o    | out | divider_word[18:0], ratio_error | valid && ready
//
// One transaction at a time: ready is high only while the sequencer idles.
// Steps per transaction: accept, align and GCD reduce together, then two
// restoring divisions (in by GCD, out by GCD), difference, stretch test,
// scale until a term reaches the top half of the field, and pack.
// Both inputs zero skips straight to the pack step with the error flag.
// The result sits in an output register, so a stalled rsp_o does not block
// the next request until the pack step. Reset clears control state only.
//
// Top level of the fractional divider ratio configuration block.
// Depends on fdrc_pkg, fdrc_if and fdrc_sub_unit.
module fractional_divider_ratio_config_unit #(
  parameter int unsigned DIVIDER_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdrc_req_if.sink   req_i,
  fdrc_rsp_if.source rsp_o
);
  import fdrc_pkg::*;

  localparam int unsigned PACK_W = FIELD_LSB + 2 * DIVIDER_WIDTH;

  state_e state_q, state_d;

  logic [FREQ_W-1:0] a_q, a_d, b_q, b_d;
  logic [CNT_W-1:0]  sh_q, sh_d;
  logic [FREQ_W-1:0] fin_q, fin_d, fout_q, fout_d;
  logic [FREQ_W-1:0] g_q, g_d;
  logic [FREQ_W-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FREQ_W-1:0] fin_red_q, fin_red_d, fout_red_q, fout_red_d;
  logic [FREQ_W-1:0] add_q, add_d, sub_q, sub_d;
  logic              stretch_q, stretch_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              out_err_q, out_err_d;

  logic              req_fire, rsp_fire;
  logic              in_both_zero, in_any_zero;
  logic              align_go, div_last, room_hit, out_free;
  logic [FREQ_W:0]   alu_x, alu_y, rem_sh;
  sub_res_t          alu_res;
  logic [FREQ_W-1:0] quo_step, rem_step;
  logic [DIVIDER_WIDTH-1:0]       neg_sub;
  logic [PACK_W+WORD_W-1:0]       pack_full;

  // Handshakes
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.divider_word = word_q;
  assign rsp_o.ratio_error  = out_err_q;

  // Sequencer conditions
  assign in_both_zero = (req_i.freq_in == '0) && (req_i.freq_out == '0);
  assign in_any_zero  = (req_i.freq_in == '0) || (req_i.freq_out == '0);
  assign align_go     = ((a_q[0] | b_q[0]) == 1'b0);
  assign div_last     = (cnt_q == CNT_LAST);
  assign room_hit     = |((add_q | sub_q) >> (DIVIDER_WIDTH - 1));
  assign out_free     = !out_valid_q || rsp_o.ready;

  // Operand select for the shared subtract unit
  assign rem_sh = {rem_q, quo_q[FREQ_W-1]};
  always_comb begin
    alu_x = '0;
    alu_y = '0;
    case (state_q)
      ST_REDUCE: begin
        alu_x = {1'b0, a_q};
        alu_y = {1'b0, b_q};
      end
      ST_DIV_IN, ST_DIV_OUT: begin
        alu_x = rem_sh;
        alu_y = {1'b0, g_q};
      end
      ST_DIFF: begin
        alu_x = {1'b0, fin_red_q};
        alu_y = {1'b0, fout_red_q};
      end
      ST_STRETCH: begin
        alu_x = {2'b00, fin_red_q[FREQ_W-1:1]};
        alu_y = {1'b0, fout_red_q};
      end
      default: begin
        alu_x = '0;
        alu_y = '0;
      end
    endcase
  end

  fdrc_sub_unit u_sub (
    .x_i   (alu_x),
    .y_i   (alu_y),
    .res_o (alu_res)
  );

  // One restoring division step
  assign quo_step = {quo_q[FREQ_W-2:0], alu_res.ge};
  assign rem_step = alu_res.ge ? alu_res.diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];

  // Word packing; zero-extended so any divider width yields WORD_W bits
  assign neg_sub   = DIVIDER_WIDTH'(0) - sub_q[DIVIDER_WIDTH-1:0];
  assign pack_full = {{WORD_W{1'b0}}, neg_sub, add_q[DIVIDER_WIDTH-1:0],
                      stretch_q, 1'b0, 1'b1};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (in_both_zero)     state_d = ST_PACK;
          else if (in_any_zero) state_d = ST_GCD_DONE;
          else                  state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (!align_go) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (a_q == '0) state_d = ST_GCD_DONE;
      end
      ST_GCD_DONE: state_d = ST_DIV_IN;
      ST_DIV_IN: begin
        if (div_last) state_d = ST_DIV_OUT;
      end
      ST_DIV_OUT: begin
        if (div_last) state_d = ST_DIFF;
      end
      ST_DIFF:    state_d = ST_STRETCH;
      ST_STRETCH: state_d = ST_SCALE;
      ST_SCALE: begin
        if (room_hit) state_d = ST_PACK;
      end
      ST_PACK: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    sh_d       = sh_q;
    fin_d      = fin_q;
    fout_d     = fout_q;
    g_d        = g_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    fin_red_d  = fin_red_q;
    fout_red_d = fout_red_q;
    add_d      = add_q;
    sub_d      = sub_q;
    stretch_d  = stretch_q;
    err_d      = err_q;
    word_d     = word_q;
    out_err_d  = out_err_q;
    out_valid_d = out_valid_q && !rsp_fire;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          fin_d  = req_i.freq_in;
          fout_d = req_i.freq_out;
          a_d    = req_i.freq_in;
          // a zero side gives the other side as the divisor
          b_d    = (req_i.freq_out == '0) ? req_i.freq_in : req_i.freq_out;
          sh_d   = '0;
          err_d  = in_both_zero;
        end
      end
      ST_ALIGN: begin
        // strip common factors of two
        if (align_go) begin
          a_d  = a_q >> 1;
          b_d  = b_q >> 1;
          sh_d = sh_q + CNT_W'(1);
        end
      end
      ST_REDUCE: begin
        if (a_q != '0) begin
          if (!a_q[0])            a_d = a_q >> 1;
          else if (!b_q[0])       b_d = b_q >> 1;
          else if (alu_res.ge)    a_d = alu_res.absdiff >> 1;
          else                    b_d = alu_res.absdiff >> 1;
        end
      end
      ST_GCD_DONE: begin
        g_d   = b_q << sh_q;
        rem_d = '0;
        quo_d = fin_q;
        cnt_d = '0;
      end
      ST_DIV_IN: begin
        if (div_last) begin
          fin_red_d = quo_step;
          rem_d     = '0;
          quo_d     = fout_q;
          cnt_d     = '0;
        end else begin
          rem_d = rem_step;
          quo_d = quo_step;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV_OUT: begin
        if (div_last) begin
          fout_red_d = quo_step;
        end else begin
          rem_d = rem_step;
          quo_d = quo_step;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIFF: begin
        add_d = alu_res.diff[FREQ_W-1:0];
        sub_d = fout_red_q;
      end
      ST_STRETCH: begin
        // reduced out <= reduced in / 2
        stretch_d = alu_res.ge;
      end
      ST_SCALE: begin
        if (!room_hit) begin
          add_d = add_q << 1;
          sub_d = sub_q << 1;
        end
      end
      ST_PACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_err_d   = err_q;
          word_d      = err_q ? '0 : pack_full[WORD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    sh_q       <= sh_d;
    fin_q      <= fin_d;
    fout_q     <= fout_d;
    g_q        <= g_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    fin_red_q  <= fin_red_d;
    fout_red_q <= fout_red_d;
    add_q      <= add_d;
    sub_q      <= sub_d;
    stretch_q  <= stretch_d;
    err_q      <= err_d;
    word_q     <= word_d;
    out_err_q  <= out_err_d;
  end

endmodule

@@ tb/tb_fractional_divider_ratio_config_unit.sv @@
// Self-checking testbench for fractional_divider_ratio_config_unit.
// Drives ratio requests, predicts each divider word and checks it on rsp_o.
// Depends on fdrc_pkg, fdrc_if and the unit under test.
module tb_fractional_divider_ratio_config_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fdrc_pkg::*;

  localparam int unsigned DIV_W          = 8;
  localparam time         CLK_PERIOD     = 8ns;
  localparam int          RESET_CYCLES   = 6;
  localparam int          RANDOM_REQS    = 430;
  localparam int          HOLD_AT_REQ    = 120;
  localparam int          HOLD_CYCLES    = 1000;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          MAX_REPORTS    = 10;

  typedef struct packed {
    logic [FREQ_W-1:0] fin;
    logic [FREQ_W-1:0] fout;
  } ratio_req_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              err;
    logic [FREQ_W-1:0] fin;
    logic [FREQ_W-1:0] fout;
  } divider_expect_t;

  logic clk_i;
  logic rst_ni;

  fdrc_req_if req_if ();
  fdrc_rsp_if rsp_if ();

  fractional_divider_ratio_config_unit #(
    .DIVIDER_WIDTH(DIV_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  ratio_req_t      pending_reqs[$];
  divider_expect_t expected_words[$];

  int   directed_reqs;
  int   reqs_accepted;
  int   words_checked;
  int   mismatch_count;
  int   error_words;
  int   stretch_words;
  int   gap_left;
  int   stall_left;
  int   idle_cycles;
  logic quiet_run;
  logic hold_rsp;

  // Divider word for one ratio: binary GCD, reduce, align terms, pack
  function automatic void calc_divider_word(input  logic [FREQ_W-1:0] fin,
                                            input  logic [FREQ_W-1:0] fout,
                                            output logic [WORD_W-1:0] word,
                                            output logic              err);
    logic [FREQ_W-1:0] a, b, g, rin, rout, add_t, sub_t, mask, room;
    logic [63:0]       packed_w;
    int unsigned       shift;
    word = '0;
    err  = 1'b0;
    if (fin == '0 && fout == '0) begin
      err = 1'b1;
      return;
    end
    a = fin;
    b = fout;
    if (a == '0) begin
      g = b;
    end else if (b == '0) begin
      g = a;
    end else begin
      shift = 0;
      while (((a | b) & 1) == 0) begin
        a >>= 1;
        b >>= 1;
        shift++;
      end
      do begin
        if (a[0] == 1'b0) a >>= 1;
        else if (b[0] == 1'b0) b >>= 1;
        else if (a >= b) a = (a - b) >> 1;
        else b = (b - a) >> 1;
      end while (a != '0);
      g = b << shift;
    end
    rin  = fin / g;
    rout = fout / g;
    add_t = rin - rout;
    sub_t = rout;
    mask  = FREQ_W'((64'd1 << DIV_W) - 64'd1);
    room  = ~(mask >> 1);
    // Scale both terms up until one reaches the top half of the field
    while (((add_t | sub_t) & room) == '0) begin
      add_t <<= 1;
      sub_t <<= 1;
    end
    packed_w = 64'd1 << ENABLE_POS;
    packed_w |= {32'd0, (FREQ_W'(0) - sub_t) & mask} << (FIELD_LSB + DIV_W);
    packed_w |= {32'd0, add_t & mask} << FIELD_LSB;
    if (rout <= rin / 2) packed_w |= 64'd1 << STRETCH_POS;
    word = packed_w[WORD_W-1:0];
  endfunction

  task automatic push_req(input logic [FREQ_W-1:0] fin, input logic [FREQ_W-1:0] fout);
    ratio_req_t r;
    r.fin  = fin;
    r.fout = fout;
    pending_reqs.push_back(r);
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Request driver: presents queued ratios, random gaps between transactions
  always @(posedge clk_i) begin
    divider_expect_t want;
    int              r;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        void'(pending_reqs.pop_front());
        calc_divider_word(req_if.freq_in, req_if.freq_out, want.word, want.err);
        want.fin  = req_if.freq_in;
        want.fout = req_if.freq_out;
        expected_words.push_back(want);
        reqs_accepted++;
        // alternate between runs with idling and runs without
        if (reqs_accepted % 64 == 0) quiet_run <= ~quiet_run;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 35) gap_left = 0;
        else if (r < 80) gap_left = $urandom_range(1, 3);
        else if (r < 95) gap_left = $urandom_range(4, 15);
        else gap_left = $urandom_range(30, 150);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_if.valid    <= 1'b1;
          req_if.freq_in  <= pending_reqs[0].fin;
          req_if.freq_out <= pending_reqs[0].fout;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word against the oldest prediction
  always @(posedge clk_i) begin
    divider_expect_t want;
    int              r;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: word=%05h err=%0b", $realtime,
                     rsp_if.divider_word, rsp_if.ratio_error);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (want.err) error_words++;
          if (want.word[STRETCH_POS]) stretch_words++;
          if (rsp_if.divider_word !== want.word || rsp_if.ratio_error !== want.err) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("[%0t] mismatch in=%08h out=%08h: word exp=%05h got=%05h, err exp=%0b got=%0b",
                       $realtime, want.fin, want.fout, want.word, rsp_if.divider_word,
                       want.err, rsp_if.ratio_error);
          end
        end
      end
      // Receiver back-pressure: long hold-off, random stalls, or always ready
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!quiet_run && $urandom_range(0, 5) == 0) begin
          r = $urandom_range(0, 99);
          if (r < 80) stall_left = $urandom_range(1, 4);
          else if (r < 95) stall_left = $urandom_range(5, 20);
          else stall_left = $urandom_range(40, 200);
        end
      end
    end
  end

  // Long receiver hold-off so the unit fills and stalls req_i
  initial begin
    hold_rsp = 1'b0;
    while (reqs_accepted < HOLD_AT_REQ) @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // Watchdog: no transaction on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [FREQ_W-1:0] a, b, k;
    int                kind;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.freq_in  = '0;
    req_if.freq_out = '0;
    rsp_if.ready    = 1'b0;
    quiet_run       = 1'b0;
    reqs_accepted   = 0;
    words_checked   = 0;
    mismatch_count  = 0;
    error_words     = 0;
    stretch_words   = 0;
    gap_left        = 0;
    stall_left      = 0;
    idle_cycles     = 0;

    // Directed: zero sides, extremes, stretch boundary, scaling corners
    push_req(32'd0, 32'd0);
    push_req(32'd0, 32'd1);
    push_req(32'd0, 32'hFFFF_FFFF);
    push_req(32'd1, 32'd0);
    push_req(32'hFFFF_FFFF, 32'd0);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(32'h8000_0000, 32'h8000_0000);
    push_req(32'hFFFF_FFFF, 32'd1);
    push_req(32'd1, 32'hFFFF_FFFF);
    push_req(32'd3, 32'd7);
    push_req(32'd100, 32'd250);
    push_req(32'd10, 32'd5);
    push_req(32'd11, 32'd5);
    push_req(32'd9, 32'd5);
    push_req(32'd2, 32'd1);
    push_req(32'd3, 32'd2);
    push_req(32'd1_000_000, 32'd115_200);
    push_req(32'd48_000_000, 32'd115_200);
    push_req(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    push_req(32'h8000_0000, 32'd1);
    push_req(32'hAAAA_AAAA, 32'h5555_5555);
    push_req(32'h1234_5678, 32'h9ABC_DEF0);
    push_req(32'd255, 32'd1);
    push_req(32'd129, 32'd1);
    push_req(32'd128, 32'd1);
    directed_reqs = pending_reqs.size();

    // Random: full-range, shared-factor, small, near-stretch-edge, close, shifted and zero-side ratios
    repeat (RANDOM_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        a = $urandom;
        b = $urandom;
      end else if (kind < 50) begin
        k = (FREQ_W'($urandom_range(1, 65535))) << $urandom_range(0, 4);
        a = FREQ_W'($urandom_range(1, 4095)) * k;
        b = FREQ_W'($urandom_range(1, 4095)) * k;
      end else if (kind < 65) begin
        a = $urandom_range(0, 300);
        b = $urandom_range(0, 300);
      end else if (kind < 75) begin
        a = $urandom;
        b = (a >> 1) + FREQ_W'($urandom_range(0, 2)) - 1;
      end else if (kind < 85) begin
        a = $urandom >> $urandom_range(0, 31);
        b = a + FREQ_W'($urandom_range(1, 1000));
      end else if (kind < 95) begin
        a = $urandom_range(1, 255) << $urandom_range(0, 24);
        b = $urandom_range(1, 255) << $urandom_range(0, 24);
      end else begin
        a = $urandom_range(0, 1) ? FREQ_W'($urandom) : '0;
        b = (a == '0) ? FREQ_W'($urandom) : '0;
      end
      push_req(a, b);
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ratio requests (%0d directed), checked %0d divider words",
             reqs_accepted, directed_reqs, words_checked);
    $display("Zero-ratio errors: %0d, stretch set: %0d, mismatches: %0d",
             error_words, stretch_words, mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
